/* design/wma_pkg.sv */
package wma_pkg;

	// Sample and average width.
	localparam int SAMPLE_W = 16;

	// Number of samples in a full window.
	localparam int WINDOW = 100;

	// Fill counter width, wide enough to hold WINDOW itself.
	localparam int CNT_W = $clog2(WINDOW + 1);

	// Running sum width, wide enough to hold WINDOW full-scale samples.
	localparam int SUM_W = $clog2(WINDOW * ((1 << SAMPLE_W) - 1) + 1);

	// The mean never exceeds the largest sample, so the quotient has SAMPLE_W bits.
	localparam int DIV_STEPS = SAMPLE_W;
	localparam int STEP_W = $clog2(DIV_STEPS);

	// Divider status seen by the control logic.
	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

/* design/windowed_moving_average_core.sv */
// Channel   Direction  Handshake                     Payload
// sample    in         sample_valid / sample_ready   sample[15:0]
// average   out        average_valid / average_ready average[15:0]
//
// The edge that accepts a beat updates the running sum and the cell chain and loads
// the divider. Sixteen restoring steps follow, and then the output register is loaded
// once it is free. The next sample is taken once the divider has handed off its
// quotient, so no new beat is accepted while the last one is still being averaged.
// Reset clears the fill count, the running sum and all handshake state.
// A stalled result holds the divider's quotient, and no sample is taken, until the
// output frees up.
module windowed_moving_average_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [wma_pkg::SAMPLE_W-1:0] sample,
	input  logic                         sample_valid,
	output logic                         sample_ready,
	output logic [wma_pkg::SAMPLE_W-1:0] average,
	output logic                         average_valid,
	input  logic                         average_ready
);
	import wma_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;

	logic [1:0]          state_q;
	logic [CNT_W-1:0]    fill_q;
	logic [SUM_W-1:0]    sum_q;
	logic [SAMPLE_W-1:0] average_q;
	logic                average_valid_q;

	logic                accept;
	logic                full;
	logic [CNT_W-1:0]    fill_next;
	logic [SUM_W-1:0]    sum_next;
	logic [SAMPLE_W-1:0] oldest;
	logic                out_free;
	div_status_t         div_status;
	logic [SAMPLE_W-1:0] quotient;
	logic [SAMPLE_W-1:0] chain [WINDOW];

	assign accept   = sample_valid && sample_ready;
	assign out_free = !average_valid_q || average_ready;

	// Chain of history cells: the newest sample enters cell 0, the oldest sits last.
	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		if (i == 0) begin : g_head
			wma_cell u_cell (
				.clk   (clk),
				.shift (accept),
				.d     (sample),
				.q     (chain[i])
			);
		end else begin : g_body
			wma_cell u_cell (
				.clk   (clk),
				.shift (accept),
				.d     (chain[i-1]),
				.q     (chain[i])
			);
		end
	end

	assign oldest = chain[WINDOW-1];

	// Running sum and fill count after this beat; the oldest sample drops out once full.
	assign full      = (fill_q == CNT_W'(WINDOW));
	assign fill_next = full ? fill_q : fill_q + 1'b1;
	assign sum_next  = sum_q + SUM_W'(sample) - (full ? SUM_W'(oldest) : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			sum_q  <= '0;
		end else if (accept) begin
			fill_q <= fill_next;
			sum_q  <= sum_next;
		end
	end

	wma_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.dividend (sum_next),
		.divisor  (fill_next),
		.status   (div_status),
		.quotient (quotient)
	);

	// Sequencer: idle, dividing, or holding a quotient for a busy output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_status.done) begin
						state_q <= out_free ? ST_IDLE : ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	logic load_out;
	assign load_out = out_free && ((state_q == ST_DIV && div_status.done) || state_q == ST_WAIT);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			average_valid_q <= 1'b0;
		end else if (load_out) begin
			average_valid_q <= 1'b1;
		end else if (average_ready) begin
			average_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			average_q <= quotient;
		end
	end

	assign sample_ready  = (state_q == ST_IDLE) && !div_status.busy;
	assign average       = average_q;
	assign average_valid = average_valid_q;

endmodule

/* design/wma_cell.sv */
module wma_cell (
	input  logic                          clk,
	input  logic                          shift,
	input  logic [wma_pkg::SAMPLE_W-1:0]  d,
	output logic [wma_pkg::SAMPLE_W-1:0]  q
);
	import wma_pkg::*;

	logic [SAMPLE_W-1:0] value_q;

	// One history slot: takes its left neighbor's sample on each accepted beat.
	always_ff @(posedge clk) begin
		if (shift) begin
			value_q <= d;
		end
	end

	assign q = value_q;

endmodule

/* design/wma_divider.sv */
module wma_divider (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [wma_pkg::SUM_W-1:0]    dividend,
	input  logic [wma_pkg::CNT_W-1:0]    divisor,
	output wma_pkg::div_status_t         status,
	output logic [wma_pkg::SAMPLE_W-1:0] quotient
);
	import wma_pkg::*;

	logic [CNT_W-1:0]    rem_q;
	logic [CNT_W-1:0]    div_q;
	logic [SAMPLE_W-1:0] quo_q;
	logic [STEP_W-1:0]   step_q;
	logic                busy_q;
	logic                done_q;
	logic [CNT_W:0]      trial;
	logic                fits;

	// One restoring step: shift in the next dividend bit and try to subtract.
	assign trial = {rem_q, quo_q[SAMPLE_W-1]} - {1'b0, div_q};
	assign fits  = ({rem_q, quo_q[SAMPLE_W-1]} >= {1'b0, div_q});

	// Datapath registers. The upper dividend bits are always below the divisor.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= CNT_W'(dividend >> SAMPLE_W);
			quo_q <= dividend[SAMPLE_W-1:0];
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? trial[CNT_W-1:0] : {rem_q[CNT_W-2:0], quo_q[SAMPLE_W-1]};
			quo_q <= {quo_q[SAMPLE_W-2:0], fits};
		end
	end

	// Step counter and busy/done flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				step_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient    = quo_q;

endmodule

/* design/wma_checker.sv */
module wma_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         sample_valid,
	input  logic                         sample_ready,
	input  logic [wma_pkg::SAMPLE_W-1:0] average,
	input  logic                         average_valid,
	input  logic                         average_ready
);

	// A stalled result beat stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		average_valid && !average_ready |=> average_valid)
		else $error("average_valid dropped before the beat was taken");

	// A stalled result beat keeps its value.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		average_valid && !average_ready |=> $stable(average))
		else $error("average changed while stalled");

	// After a sample beat the block is busy dividing and does not take the next sample at once.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> !sample_ready ##1 !sample_ready)
		else $error("sample_ready returned too early after a beat");

	// A new result appears only while a sample beat is in flight.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(average_valid) |-> $past(!sample_ready))
		else $error("result appeared with no sample in flight");

endmodule

bind windowed_moving_average_core wma_checker u_wma_checker (.*);

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
	import wma_pkg::*;

	localparam int CLK_HALF = 5;
	localparam int RANDOM_BEATS = 1950;
	localparam int IDLE_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 40;
	localparam logic [SAMPLE_W-1:0] FULL_SCALE = '1;

	// Kinds of sample runs in the random part of the stimulus.
	typedef enum int {
		RUN_ANY,
		RUN_FULL_SCALE,
		RUN_ZERO,
		RUN_LOW,
		RUN_HIGH
	} sample_run_t;

	// Receiver back-pressure modes.
	typedef enum int {
		RX_FREE,
		RX_RANDOM,
		RX_SPARSE
	} stall_mode_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic [SAMPLE_W-1:0] sample = '0;
	logic                sample_valid = 1'b0;
	logic                sample_ready;
	logic [SAMPLE_W-1:0] average;
	logic                average_valid;
	logic                average_ready = 1'b0;

	// Samples waiting to be driven and averages waiting to come out.
	logic [SAMPLE_W-1:0] pending_samples[$];
	logic [SAMPLE_W-1:0] expected_averages[$];

	// Shadow copy of the window state.
	logic [SAMPLE_W-1:0] window_history[WINDOW];
	logic [CNT_W-1:0]    next_slot = '0;
	logic [CNT_W-1:0]    samples_held = '0;
	logic [SUM_W-1:0]    running_sum = '0;

	logic        sample_taken = 1'b0;
	int          fail_count = 0;
	int          idle_cycles = 0;
	int          burst_left = 0;
	int          gap_left = 0;
	int          stall_phase_left = 0;
	logic [31:0] stall_bits = '1;
	stall_mode_t stall_mode = RX_FREE;

	windowed_moving_average_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample        (sample),
		.sample_valid  (sample_valid),
		.sample_ready  (sample_ready),
		.average       (average),
		.average_valid (average_valid),
		.average_ready (average_ready)
	);

	always #CLK_HALF clk = ~clk;

	// Adds one sample to the shadow window and returns the truncated mean.
	function automatic logic [SAMPLE_W-1:0] push_window_sample(input logic [SAMPLE_W-1:0] s);
		logic [SUM_W-1:0] quotient;
		if (samples_held >= CNT_W'(WINDOW)) begin
			running_sum = running_sum - SUM_W'(window_history[next_slot]);
		end else begin
			samples_held = samples_held + 1'b1;
		end
		window_history[next_slot] = s;
		running_sum = running_sum + SUM_W'(s);
		if (next_slot == CNT_W'(WINDOW - 1))
			next_slot = '0;
		else
			next_slot = next_slot + 1'b1;
		quotient = running_sum / SUM_W'(samples_held);
		return quotient[SAMPLE_W-1:0];
	endfunction

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t: %s", $realtime, msg);
	endtask

	// Input beats feed the shadow window; output beats are checked in order.
	always @(posedge clk) begin
		if (arst_n) begin
			sample_taken <= sample_valid && sample_ready;
			if (sample_valid && sample_ready)
				expected_averages.push_back(push_window_sample(sample));
			if (average_valid && average_ready) begin
				if (expected_averages.size() == 0) begin
					note_failure($sformatf("unexpected average %0d", average));
				end else if (average !== expected_averages[0]) begin
					note_failure($sformatf("average mismatch: expected %0d, got %0d",
						expected_averages[0], average));
					void'(expected_averages.pop_front());
				end else begin
					void'(expected_averages.pop_front());
				end
			end
			// Watchdog on cycles without any beat.
			if ((sample_valid && sample_ready) || (average_valid && average_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// Sender: bursts of random length separated by random gaps.
	always @(negedge clk) begin
		if (arst_n && (!sample_valid || sample_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				sample_valid <= 1'b0;
			end else if (pending_samples.size() > 0) begin
				sample <= pending_samples.pop_front();
				sample_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 250)
						: $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left--;
				end
			end else begin
				sample_valid <= 1'b0;
			end
		end
	end

	// Receiver: a rotating stall pattern in a random mode, reloaded when its phase count runs out.
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_phase_left == 0) begin
				stall_phase_left = 64;
				stall_mode = stall_mode_t'($urandom_range(0, 2));
				if (stall_mode == RX_FREE)
					stall_bits = '1;
				else if (stall_mode == RX_RANDOM)
					stall_bits = $urandom;
				else
					stall_bits = $urandom & $urandom & $urandom;
			end
			stall_phase_left--;
			average_ready <= stall_bits[0];
			stall_bits = {stall_bits[0], stall_bits[31:1]};
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		int run_len;
		int target;
		sample_run_t run_kind;

		// Directed: first sample passes through, then field extremes and bit patterns.
		pending_samples.push_back(FULL_SCALE);
		pending_samples.push_back('0);
		pending_samples.push_back(FULL_SCALE);
		pending_samples.push_back(16'h0001);
		pending_samples.push_back(16'h8000);
		pending_samples.push_back(16'hAAAA);
		pending_samples.push_back(16'h5555);
		pending_samples.push_back(16'h7FFF);
		for (int i = 0; i < 6; i++)
			pending_samples.push_back(FULL_SCALE);
		for (int i = 0; i < 6; i++)
			pending_samples.push_back('0);
		pending_samples.push_back(16'hFFFE);
		pending_samples.push_back(16'h0100);

		// Random runs; full-scale runs of up to 150 samples, some long enough to fill the whole window.
		target = pending_samples.size() + RANDOM_BEATS;
		while (pending_samples.size() < target) begin
			run_kind = sample_run_t'($urandom_range(0, 4));
			if (run_kind == RUN_ANY)
				run_len = $urandom_range(20, 200);
			else if (run_kind == RUN_FULL_SCALE)
				run_len = $urandom_range(20, 150);
			else
				run_len = $urandom_range(5, 60);
			for (int i = 0; i < run_len; i++) begin
				if (run_kind == RUN_ANY)
					pending_samples.push_back(SAMPLE_W'($urandom));
				else if (run_kind == RUN_FULL_SCALE)
					pending_samples.push_back(FULL_SCALE);
				else if (run_kind == RUN_ZERO)
					pending_samples.push_back('0);
				else if (run_kind == RUN_LOW)
					pending_samples.push_back(SAMPLE_W'($urandom_range(0, 15)));
				else
					pending_samples.push_back(SAMPLE_W'($urandom_range(65520, 65535)));
			end
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_samples.size() > 0 || sample_valid || expected_averages.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

/* windowed_moving_average_core.f */
design/wma_pkg.sv
design/wma_cell.sv
design/wma_divider.sv
design/windowed_moving_average_core.sv
design/wma_checker.sv
bench/tb_top.sv
